@@ rtl/fixed_block_pool_allocator_defines.svh @@
// Assertion macros shared by the fixed block pool allocator RTL.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FBPA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fbpa assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FBPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fbpa assertion failed");

`endif

@@ rtl/fbpa_pkg.sv @@
// Types and constants of the fixed block pool allocator.
package fbpa_pkg;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam logic CSR_NUM_BLOCKS = 1'b0;
   localparam logic CSR_BLOCK_SIZE = 1'b1;

   typedef struct packed {
      logic       action;
      logic [7:0] block_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  granted_index;
      logic [23:0] word_offset;
      logic [8:0]  free_left;
   } rsp_type;

   typedef struct packed {
      logic       wr_en;
      logic [7:0] wr_addr;
      logic [8:0] wr_data;
      logic       rd_en;
      logic [7:0] rd_addr;
   } link_cmd_type;

endpackage

@@ rtl/fbpa_link_mem.sv @@
// Link memory of the free list: one write port and one registered read port.
module fbpa_link_mem #(
   parameter int unsigned DEPTH = 256
) (
   input  logic                  clock,
   input  fbpa_pkg::link_cmd_type cmd,
   output logic [8:0]            rd_data
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [8:0] mem [DEPTH];
   logic [8:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr[AW-1:0]] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/fixed_block_pool_allocator.sv @@
// Fixed block pool allocator: top level with sequencer, pool state and response register.
// A transaction is taken in the idle step; in the access step the link memory read is
// registered, and in the commit step the response is registered, which waits while
// an earlier response has not been taken. Only the idle step takes a new transaction,
// so each one passes through the idle, access and commit steps before the next.
// Reset is synchronous; the pool comes up with 256 blocks (or MAX_BLOCKS if fewer) free,
// and the link memory is initialized lazily, so no clearing pass is needed.
`include "fixed_block_pool_allocator_defines.svh"

module fixed_block_pool_allocator #(
   parameter int unsigned MAX_BLOCKS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fbpa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fbpa_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [0:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   localparam int unsigned DEPTH = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;
   localparam logic [8:0]  BLK_LIMIT = 9'(DEPTH);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EXEC   = 2'd1;
   localparam logic [1:0] S_COMMIT = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [8:0]              head_ff, head_in;
   logic [8:0]              touched_ff, touched_in;
   logic [8:0]              free_ff, free_in;
   logic [8:0]              num_ff, num_in;
   logic [15:0]             bsize_ff, bsize_in;
   fbpa_pkg::req_type       req_ff, req_in;
   logic [1:0]              st_ff, st_in;
   logic [7:0]              grant_ff, grant_in;
   logic                    last_ff, last_in;
   logic                    bypass_ff, bypass_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   fbpa_pkg::rsp_type       rsp_ff, rsp_in;
   fbpa_pkg::link_cmd_type  link_cmd;
   logic [8:0]              link_rd;
   logic [8:0]              csr_num;
   logic                    lazy;
   logic                    fail;

   fbpa_link_mem #(
      .DEPTH(DEPTH)
   ) u_link_mem (
      .clock   (clock),
      .cmd     (link_cmd),
      .rd_data (link_rd)
   );

   always_comb begin
      csr_num = csr_wdata[8:0];
      if (csr_num == 9'd0) begin
         csr_num = 9'd1;
      end else if (csr_num > BLK_LIMIT) begin
         csr_num = BLK_LIMIT;
      end
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      touched_in   = touched_ff;
      free_in      = free_ff;
      num_in       = num_ff;
      bsize_in     = bsize_ff;
      req_in       = req_ff;
      st_in        = st_ff;
      grant_in     = grant_ff;
      last_in      = last_ff;
      bypass_in    = bypass_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      link_cmd     = '0;
      lazy         = touched_ff < num_ff;
      fail         = (free_ff == 9'd0) || (head_ff >= num_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in  = S_COMMIT;
            last_in   = free_ff == 9'd1;
            bypass_in = 1'b0;
            grant_in  = 8'd0;
            if (req_ff.action == fbpa_pkg::ACT_ALLOC) begin
               if (lazy) begin
                  link_cmd.wr_en   = 1'b1;
                  link_cmd.wr_addr = touched_ff[7:0];
                  link_cmd.wr_data = touched_ff + 9'd1;
                  touched_in       = touched_ff + 9'd1;
               end
               bypass_in        = lazy && (head_ff == touched_ff);
               link_cmd.rd_en   = 1'b1;
               link_cmd.rd_addr = head_ff[7:0];
               if (fail) begin
                  st_in = fbpa_pkg::ST_EMPTY;
               end else begin
                  st_in    = fbpa_pkg::ST_OK;
                  grant_in = head_ff[7:0];
                  free_in  = free_ff - 9'd1;
               end
            end else begin
               if ({1'b0, req_ff.block_index} >= num_ff) begin
                  st_in = fbpa_pkg::ST_RANGE;
               end else if (free_ff >= num_ff) begin
                  st_in = fbpa_pkg::ST_FULL;
               end else begin
                  st_in            = fbpa_pkg::ST_OK;
                  link_cmd.wr_en   = 1'b1;
                  link_cmd.wr_addr = req_ff.block_index;
                  link_cmd.wr_data = head_ff;
                  head_in          = {1'b0, req_ff.block_index};
                  free_in          = free_ff + 9'd1;
               end
            end
         end
         S_COMMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = st_ff;
               rsp_in.granted_index = grant_ff;
               rsp_in.word_offset   = 24'(grant_ff) * 24'(bsize_ff);
               rsp_in.free_left     = free_ff;
               if (req_ff.action == fbpa_pkg::ACT_ALLOC && st_ff == fbpa_pkg::ST_OK) begin
                  if (last_ff) begin
                     head_in = num_ff;
                  end else if (bypass_ff) begin
                     head_in = touched_ff;
                  end else begin
                     head_in = link_rd;
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_we) begin
         case (csr_index[0])
            fbpa_pkg::CSR_NUM_BLOCKS: begin
               num_in     = csr_num;
               head_in    = 9'd0;
               touched_in = 9'd0;
               free_in    = csr_num;
            end
            fbpa_pkg::CSR_BLOCK_SIZE: begin
               bsize_in = csr_wdata;
            end
            default: begin
               bsize_in = bsize_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= 9'd0;
         touched_ff   <= 9'd0;
         free_ff      <= BLK_LIMIT;
         num_ff       <= BLK_LIMIT;
         bsize_ff     <= 16'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         touched_ff   <= touched_in;
         free_ff      <= free_in;
         num_ff       <= num_in;
         bsize_ff     <= bsize_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff    <= req_in;
      st_ff     <= st_in;
      grant_ff  <= grant_in;
      last_ff   <= last_in;
      bypass_ff <= bypass_in;
      rsp_ff    <= rsp_in;
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `FBPA_ASSERT_NOW(a_free_bound, clock, reset, 1'b1, free_ff <= num_ff)
   `FBPA_ASSERT_NOW(a_touched_bound, clock, reset, 1'b1, touched_ff <= num_ff)
   `FBPA_ASSERT_NEXT(a_accept_exec, clock, reset, req_valid && req_ready, state_ff == S_EXEC)
   `FBPA_ASSERT_NEXT(a_commit_load, clock, reset,
      state_ff == S_COMMIT && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && state_ff == S_IDLE)

endmodule
